// File: rtl/boids_flock_update_macros.svh
// Assertion shorthands shared by the flock update RTL.
`ifndef BOIDS_FLOCK_UPDATE_MACROS_SVH
`define BOIDS_FLOCK_UPDATE_MACROS_SVH

// Same-cycle implication, quiet while in reset.
`define BFU_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, quiet while in reset.
`define BFU_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/bfu_pkg.sv
`timescale 1ns / 1ps

package bfu_pkg;

	localparam int MAX_BIRDS = 64;
	localparam int TBL_AW    = $clog2(MAX_BIRDS);
	localparam int CNT_W     = $clog2(MAX_BIRDS + 1);
	localparam int SUM_W     = 17 + CNT_W;

	localparam int MUL_AW = SUM_W;
	localparam int MUL_BW = 18;
	localparam int PROD_W = MUL_AW + MUL_BW;

	localparam int DIV_NW = 41;
	localparam int DIV_DW = 24;
	localparam int DIV_CW = $clog2(DIV_NW + 1);

	localparam int SQ_RW = 48;
	localparam int SQ_QW = SQ_RW / 2;
	localparam int SQ_CW = $clog2(SQ_QW + 1);

	localparam int SCREEN_WIDTH  = 1280;
	localparam int SCREEN_HEIGHT = 720;
	localparam int MARGIN_X      = 100;
	localparam int MARGIN_Y      = 100;
	localparam int TIME_STEP     = 1092;

	localparam logic ACT_LOAD   = 1'b0;
	localparam logic ACT_UPDATE = 1'b1;

	typedef struct packed {
		logic               action;
		logic        [5:0]  bird_index;
		logic signed [15:0] load_pos_x;
		logic signed [15:0] load_pos_y;
		logic signed [15:0] load_vel_x;
		logic signed [15:0] load_vel_y;
	} item_t;

	typedef struct packed {
		logic        [5:0]  out_index;
		logic signed [15:0] new_pos_x;
		logic signed [15:0] new_pos_y;
		logic signed [15:0] new_vel_x;
		logic signed [15:0] new_vel_y;
		logic               saturated;
	} result_t;

	typedef struct packed {
		logic signed [15:0] px;
		logic signed [15:0] py;
		logic signed [15:0] vx;
		logic signed [15:0] vy;
	} bird_t;

	typedef struct packed {
		logic              en;
		logic [TBL_AW-1:0] addr;
		bird_t             data;
	} tbl_wr_t;

	typedef struct packed {
		logic                     start;
		logic signed [DIV_NW-1:0] dividend;
		logic        [DIV_DW-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic                     busy;
		logic                     done;
		logic signed [DIV_NW-1:0] quot;
	} div_rsp_t;

	typedef struct packed {
		logic             start;
		logic [SQ_RW-1:0] rad;
	} sqrt_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [SQ_QW-1:0] root;
	} sqrt_rsp_t;

endpackage

// File: rtl/bfu_table.sv
`timescale 1ns / 1ps

module bfu_table import bfu_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  tbl_wr_t           wr,
	input  logic              rd_en,
	input  logic [TBL_AW-1:0] rd_addr,
	output bird_t             rd_data,
	output logic [MAX_BIRDS-1:0] valid
);

	bird_t mem [MAX_BIRDS];
	bird_t rd_data_q;
	logic [MAX_BIRDS-1:0] valid_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr.en) begin
			valid_q[wr.addr] <= 1'b1;
		end
	end

	assign rd_data = rd_data_q;
	assign valid   = valid_q;

endmodule

// File: rtl/bfu_div.sv
`timescale 1ns / 1ps

module bfu_div import bfu_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [DIV_NW-1:0] num_q;
	logic [DIV_DW-1:0] den_q;
	logic [DIV_DW-1:0] rem_q;
	logic [DIV_CW-1:0] cnt_q;
	logic              neg_q;
	logic              busy_q;
	logic              done_q;
	logic [DIV_DW:0]   trial;
	logic [DIV_DW:0]   diff;
	logic              ge;

	assign trial = {rem_q, num_q[DIV_NW-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			neg_q  <= 1'b0;
			num_q  <= '0;
			den_q  <= '0;
			rem_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CW'(DIV_NW);
				neg_q  <= req.dividend[DIV_NW-1];
				num_q  <= req.dividend[DIV_NW-1] ? DIV_NW'(-req.dividend) : DIV_NW'(req.dividend);
				den_q  <= req.divisor;
				rem_q  <= '0;
			end else if (busy_q) begin
				if (ge) begin
					rem_q <= diff[DIV_DW-1:0];
					num_q <= {num_q[DIV_NW-2:0], 1'b1};
				end else begin
					rem_q <= trial[DIV_DW-1:0];
					num_q <= {num_q[DIV_NW-2:0], 1'b0};
				end
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quot = neg_q ? DIV_NW'(-num_q) : num_q;

endmodule

// File: rtl/bfu_sqrt.sv
`timescale 1ns / 1ps

module bfu_sqrt import bfu_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  sqrt_req_t req,
	output sqrt_rsp_t rsp
);

	logic [SQ_RW-1:0]   rad_q;
	logic [SQ_QW-1:0]   root_q;
	logic [SQ_QW+1:0]   rem_q;
	logic [SQ_CW-1:0]   cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [SQ_QW+1:0]   trial_rem;
	logic [SQ_QW+1:0]   trial;

	assign trial_rem = {rem_q[SQ_QW-1:0], rad_q[SQ_RW-1:SQ_RW-2]};
	assign trial     = {root_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rad_q  <= '0;
			root_q <= '0;
			rem_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= SQ_CW'(SQ_QW);
				rad_q  <= req.rad;
				root_q <= '0;
				rem_q  <= '0;
			end else if (busy_q) begin
				if (trial_rem >= trial) begin
					rem_q  <= trial_rem - trial;
					root_q <= {root_q[SQ_QW-2:0], 1'b1};
				end else begin
					rem_q  <= trial_rem;
					root_q <= {root_q[SQ_QW-2:0], 1'b0};
				end
				rad_q <= {rad_q[SQ_RW-3:0], 2'b00};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == SQ_CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.root = root_q;

endmodule

// File: rtl/boids_flock_update.sv
// Boids flocking step over a table of 64 birds. A word is taken when start is high and busy
// is low. A load word writes one bird and gives no result; busy stays low. An update word of
// a valid bird raises busy while one shared multiplier, a one-bit-a-cycle divider and a
// two-bits-a-cycle square root are stepped by the sequencer: set-up, a visit to every table
// entry (skipped for an empty or own entry, distance and sums for each other valid bird),
// the separation step, up to four averaging divisions, a root when the speed is not zero,
// up to four speed-scaling divisions, and the position step and write-back. The result is
// shown for exactly one cycle on done and cannot be held off by the receiver. An update of an
// empty entry is dropped and gives no result. Reset clears the valid bits at once; there is no
// clearing pass. cfg_ready is always high; write registers only while the block is idle.
`timescale 1ns / 1ps

module boids_flock_update import bfu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  item_t       item,
	output logic        done,
	output result_t     result,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

`include "boids_flock_update_macros.svh"

	localparam logic [2:0] REG_SEP_R = 3'd0;
	localparam logic [2:0] REG_ALI_R = 3'd1;
	localparam logic [2:0] REG_COH_R = 3'd2;
	localparam logic [2:0] REG_SEP_G = 3'd3;
	localparam logic [2:0] REG_ALI_G = 3'd4;
	localparam logic [2:0] REG_COH_G = 3'd5;
	localparam logic [2:0] REG_TURN  = 3'd6;
	localparam logic [2:0] REG_LIMIT = 3'd7;

	localparam logic signed [16:0] X_LO = 17'(MARGIN_X * 16);
	localparam logic signed [16:0] X_HI = 17'((SCREEN_WIDTH - MARGIN_X) * 16);
	localparam logic signed [16:0] Y_LO = 17'(MARGIN_Y * 16);
	localparam logic signed [16:0] Y_HI = 17'((SCREEN_HEIGHT - MARGIN_Y) * 16);

	typedef enum logic [5:0] {
		S_IDLE, S_SELF, S_R2A, S_R2C, S_R2W, S_RD, S_DX, S_DY, S_ACC,
		S_SEPX, S_SEPY, S_SEPW, S_AVX_W, S_AVX_M, S_AVY_W, S_AVY_M,
		S_CPX_W, S_CPX_M, S_CPY_W, S_CPY_M, S_TURN, S_SQ1, S_SQ2, S_SQ3, S_SQ4,
		S_SQRT_W, S_LIM, S_LX_M, S_LX_W, S_LY_M, S_LY_W, S_POSX, S_POSY, S_WB
	} state_t;

	typedef struct packed {
		logic               clip;
		logic signed [15:0] val;
	} sat_t;

	function automatic sat_t sat16(input logic signed [47:0] x);
		sat_t r;
		if (x > 48'sd32767) begin
			r.clip = 1'b1;
			r.val  = 16'sh7fff;
		end else if (x < -48'sd32768) begin
			r.clip = 1'b1;
			r.val  = 16'sh8000;
		end else begin
			r.clip = 1'b0;
			r.val  = x[15:0];
		end
		return r;
	endfunction

	function automatic logic signed [PROD_W:0] rshr(input logic signed [PROD_W-1:0] x,
			input int unsigned s);
		logic signed [PROD_W:0] xe;
		xe = {x[PROD_W-1], x} + ((PROD_W+1)'(1) << (s - 1));
		return xe >>> s;
	endfunction

	function automatic sat_t add_sat(input logic signed [15:0] b,
			input logic signed [PROD_W:0] inc);
		logic signed [47:0] s;
		s = 48'(b) + 48'(inc);
		return sat16(s);
	endfunction

	// configuration
	logic [14:0] sep_r_q, ali_r_q, coh_r_q, turn_q;
	logic [15:0] sep_g_q, ali_g_q, coh_g_q;
	logic [31:0] limits_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sep_r_q  <= 15'd128;
			ali_r_q  <= 15'd640;
			coh_r_q  <= 15'd640;
			sep_g_q  <= 16'd3277;
			ali_g_q  <= 16'd3277;
			coh_g_q  <= 16'd328;
			turn_q   <= 15'd51;
			limits_q <= 32'd251659008;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_SEP_R: sep_r_q  <= cfg_data[14:0];
				REG_ALI_R: ali_r_q  <= cfg_data[14:0];
				REG_COH_R: coh_r_q  <= cfg_data[14:0];
				REG_SEP_G: sep_g_q  <= cfg_data[15:0];
				REG_ALI_G: ali_g_q  <= cfg_data[15:0];
				REG_COH_G: coh_g_q  <= cfg_data[15:0];
				REG_TURN:  turn_q   <= cfg_data[14:0];
				REG_LIMIT: limits_q <= cfg_data;
			endcase
		end
	end

	// sequencer state and datapath registers
	state_t              state_q;
	logic                done_q;
	result_t             result_q;
	logic [TBL_AW-1:0]   self_q;
	logic [5:0]          idx_q;
	logic signed [15:0]  px_q, py_q, vx_q, vy_q;
	bird_t               o_q;
	logic signed [16:0]  dx_q, dy_q;
	logic [32:0]         d2_q;
	logic [29:0]         r2s_q, r2a_q, r2c_q;
	logic signed [SUM_W-1:0] sdx_q, sdy_q, avx_q, avy_q, apx_q, apy_q;
	logic [CNT_W-1:0]    na_q, nc_q, j_q;
	logic                sat_q;
	logic [31:0]         sq_q, s2_q, max2_q, min2_q;
	logic [SQ_QW-1:0]    spd_q;
	logic                lim_sel_q;
	logic signed [PROD_W-1:0] prod_q;

	logic signed [MUL_AW-1:0] mul_a;
	logic signed [MUL_BW-1:0] mul_b;

	tbl_wr_t             tbl_wr;
	logic                tbl_rd_en;
	logic [TBL_AW-1:0]   tbl_rd_addr;
	bird_t               tbl_rd;
	logic [MAX_BIRDS-1:0] tbl_valid;

	div_req_t            div_req;
	div_rsp_t            div_rsp;
	sqrt_req_t           sqrt_req;
	sqrt_rsp_t           sqrt_rsp;

	logic                accept;
	logic                idx_ok;
	logic [TBL_AW-1:0]   in_addr;
	logic [TBL_AW-1:0]   j_addr;
	logic                skip;
	logic signed [16:0]  dx_c, dy_c;
	logic [33:0]         d2;
	logic signed [15:0]  q16;
	logic signed [16:0]  avx_d, avy_d, cpx_d, cpy_d;
	logic signed [17:0]  tval, vxt, vyt;
	sat_t                tx, ty, upd;
	logic signed [PROD_W:0] r12, r16, r20;
	logic [15:0]         lim;

	bfu_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (tbl_wr),
		.rd_en   (tbl_rd_en),
		.rd_addr (tbl_rd_addr),
		.rd_data (tbl_rd),
		.valid   (tbl_valid)
	);

	bfu_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	bfu_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (sqrt_req),
		.rsp    (sqrt_rsp)
	);

	assign busy    = (state_q != S_IDLE);
	assign accept  = start && !busy;
	assign idx_ok  = (32'(item.bird_index) < MAX_BIRDS);
	assign in_addr = TBL_AW'(item.bird_index);
	assign j_addr  = j_q[TBL_AW-1:0];
	assign skip    = (j_addr == self_q) || !tbl_valid[j_addr];

	assign dx_c  = px_q - tbl_rd.px;
	assign dy_c  = py_q - tbl_rd.py;
	assign d2    = {1'b0, d2_q} + {1'b0, prod_q[32:0]};
	assign q16   = div_rsp.quot[15:0];
	assign avx_d = q16 - vx_q;
	assign avy_d = q16 - vy_q;
	assign cpx_d = q16 - px_q;
	assign cpy_d = q16 - py_q;
	assign tval  = 18'(turn_q);
	assign vxt   = 18'(vx_q) + ((17'(px_q) < X_LO) ? tval : 18'sd0)
		- ((17'(px_q) > X_HI) ? tval : 18'sd0);
	assign vyt   = 18'(vy_q) + ((17'(py_q) < Y_LO) ? tval : 18'sd0)
		- ((17'(py_q) > Y_HI) ? tval : 18'sd0);
	assign tx    = sat16(48'(vxt));
	assign ty    = sat16(48'(vyt));
	assign r12   = rshr(prod_q, 12);
	assign r16   = rshr(prod_q, 16);
	assign r20   = rshr(prod_q, 20);
	assign lim   = lim_sel_q ? limits_q[15:0] : limits_q[31:16];

	always_comb begin
		case (state_q)
			S_SEPY, S_CPX_M:  upd = add_sat(vx_q, r12);
			S_SEPW, S_CPY_M:  upd = add_sat(vy_q, r12);
			S_AVX_M:          upd = add_sat(vx_q, r16);
			S_AVY_M:          upd = add_sat(vy_q, r16);
			S_LX_W, S_LY_W:   upd = sat16(48'(div_rsp.quot));
			S_POSY:           upd = add_sat(px_q, r20);
			S_WB:             upd = add_sat(py_q, r20);
			default:          upd = '0;
		endcase
	end

	// shared multiplier operands
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_SELF:  begin mul_a = MUL_AW'(sep_r_q); mul_b = MUL_BW'(sep_r_q); end
			S_R2A:   begin mul_a = MUL_AW'(ali_r_q); mul_b = MUL_BW'(ali_r_q); end
			S_R2C:   begin mul_a = MUL_AW'(coh_r_q); mul_b = MUL_BW'(coh_r_q); end
			S_DX:    begin mul_a = MUL_AW'(dx_c);    mul_b = MUL_BW'(dx_c);    end
			S_DY:    begin mul_a = MUL_AW'(dy_q);    mul_b = MUL_BW'(dy_q);    end
			S_SEPX:  begin mul_a = sdx_q;            mul_b = MUL_BW'(sep_g_q); end
			S_SEPY:  begin mul_a = sdy_q;            mul_b = MUL_BW'(sep_g_q); end
			S_AVX_W: begin mul_a = MUL_AW'(avx_d);   mul_b = MUL_BW'(ali_g_q); end
			S_AVY_W: begin mul_a = MUL_AW'(avy_d);   mul_b = MUL_BW'(ali_g_q); end
			S_CPX_W: begin mul_a = MUL_AW'(cpx_d);   mul_b = MUL_BW'(coh_g_q); end
			S_CPY_W: begin mul_a = MUL_AW'(cpy_d);   mul_b = MUL_BW'(coh_g_q); end
			S_TURN:  begin mul_a = MUL_AW'(tx.val);  mul_b = MUL_BW'(tx.val);  end
			S_SQ1:   begin mul_a = MUL_AW'(vy_q);    mul_b = MUL_BW'(vy_q);    end
			S_SQ2:   begin
				mul_a = MUL_AW'(limits_q[31:16]);
				mul_b = MUL_BW'(limits_q[31:16]);
			end
			S_SQ3:   begin
				mul_a = MUL_AW'(limits_q[15:0]);
				mul_b = MUL_BW'(limits_q[15:0]);
			end
			S_LIM:   begin mul_a = MUL_AW'(vx_q);    mul_b = MUL_BW'(lim);     end
			S_LX_W:  begin mul_a = MUL_AW'(vy_q);    mul_b = MUL_BW'(lim);     end
			S_POSX:  begin mul_a = MUL_AW'(vx_q);    mul_b = MUL_BW'(TIME_STEP); end
			S_POSY:  begin mul_a = MUL_AW'(vy_q);    mul_b = MUL_BW'(TIME_STEP); end
			default: begin mul_a = '0;               mul_b = '0;               end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// divider, root and table requests
	always_comb begin
		div_req.start    = 1'b0;
		div_req.dividend = '0;
		div_req.divisor  = '0;
		case (state_q)
			S_SEPW: begin
				div_req.start    = (na_q != '0) || (nc_q != '0);
				div_req.dividend = (na_q != '0) ? DIV_NW'(avx_q) : DIV_NW'(apx_q);
				div_req.divisor  = (na_q != '0) ? DIV_DW'(na_q) : DIV_DW'(nc_q);
			end
			S_AVX_M: begin
				div_req.start    = 1'b1;
				div_req.dividend = DIV_NW'(avy_q);
				div_req.divisor  = DIV_DW'(na_q);
			end
			S_AVY_M: begin
				div_req.start    = (nc_q != '0);
				div_req.dividend = DIV_NW'(apx_q);
				div_req.divisor  = DIV_DW'(nc_q);
			end
			S_CPX_M: begin
				div_req.start    = 1'b1;
				div_req.dividend = DIV_NW'(apy_q);
				div_req.divisor  = DIV_DW'(nc_q);
			end
			S_LX_M, S_LY_M: begin
				div_req.start    = 1'b1;
				div_req.dividend = DIV_NW'(prod_q) <<< 8;
				div_req.divisor  = DIV_DW'(spd_q);
			end
			default: begin
				div_req.start = 1'b0;
			end
		endcase
	end

	assign sqrt_req.start = (state_q == S_SQ4) && (s2_q != '0);
	assign sqrt_req.rad   = {s2_q, 16'b0};

	assign tbl_rd_en   = (state_q == S_IDLE) || (state_q == S_RD);
	assign tbl_rd_addr = (state_q == S_IDLE) ? in_addr : j_addr;

	always_comb begin
		tbl_wr.en   = 1'b0;
		tbl_wr.addr = in_addr;
		tbl_wr.data = {item.load_pos_x, item.load_pos_y, item.load_vel_x, item.load_vel_y};
		if (state_q == S_WB) begin
			tbl_wr.en   = 1'b1;
			tbl_wr.addr = self_q;
			tbl_wr.data = {px_q, upd.val, vx_q, vy_q};
		end else if (state_q == S_IDLE) begin
			tbl_wr.en = accept && (item.action == ACT_LOAD) && idx_ok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			done_q    <= 1'b0;
			result_q  <= '0;
			self_q    <= '0;
			idx_q     <= '0;
			px_q      <= '0;
			py_q      <= '0;
			vx_q      <= '0;
			vy_q      <= '0;
			o_q       <= '0;
			dx_q      <= '0;
			dy_q      <= '0;
			d2_q      <= '0;
			r2s_q     <= '0;
			r2a_q     <= '0;
			r2c_q     <= '0;
			sdx_q     <= '0;
			sdy_q     <= '0;
			avx_q     <= '0;
			avy_q     <= '0;
			apx_q     <= '0;
			apy_q     <= '0;
			na_q      <= '0;
			nc_q      <= '0;
			j_q       <= '0;
			sat_q     <= 1'b0;
			sq_q      <= '0;
			s2_q      <= '0;
			max2_q    <= '0;
			min2_q    <= '0;
			spd_q     <= '0;
			lim_sel_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept && (item.action == ACT_UPDATE) && idx_ok && tbl_valid[in_addr]) begin
						self_q  <= in_addr;
						idx_q   <= item.bird_index;
						state_q <= S_SELF;
					end
				end
				S_SELF: begin
					px_q    <= tbl_rd.px;
					py_q    <= tbl_rd.py;
					vx_q    <= tbl_rd.vx;
					vy_q    <= tbl_rd.vy;
					sat_q   <= 1'b0;
					sdx_q   <= '0;
					sdy_q   <= '0;
					avx_q   <= '0;
					avy_q   <= '0;
					apx_q   <= '0;
					apy_q   <= '0;
					na_q    <= '0;
					nc_q    <= '0;
					j_q     <= '0;
					state_q <= S_R2A;
				end
				S_R2A: begin
					r2s_q   <= prod_q[29:0];
					state_q <= S_R2C;
				end
				S_R2C: begin
					r2a_q   <= prod_q[29:0];
					state_q <= S_R2W;
				end
				S_R2W: begin
					r2c_q   <= prod_q[29:0];
					state_q <= S_RD;
				end
				S_RD: begin
					if (j_q == CNT_W'(MAX_BIRDS)) begin
						state_q <= S_SEPX;
					end else if (skip) begin
						j_q <= j_q + 1'b1;
					end else begin
						state_q <= S_DX;
					end
				end
				S_DX: begin
					o_q     <= tbl_rd;
					dx_q    <= dx_c;
					dy_q    <= dy_c;
					state_q <= S_DY;
				end
				S_DY: begin
					d2_q    <= prod_q[32:0];
					state_q <= S_ACC;
				end
				S_ACC: begin
					if (d2 < 34'(r2s_q)) begin
						sdx_q <= sdx_q + SUM_W'(dx_q);
						sdy_q <= sdy_q + SUM_W'(dy_q);
					end
					if (d2 < 34'(r2a_q)) begin
						avx_q <= avx_q + SUM_W'(o_q.vx);
						avy_q <= avy_q + SUM_W'(o_q.vy);
						na_q  <= na_q + 1'b1;
					end
					if (d2 < 34'(r2c_q)) begin
						apx_q <= apx_q + SUM_W'(o_q.px);
						apy_q <= apy_q + SUM_W'(o_q.py);
						nc_q  <= nc_q + 1'b1;
					end
					j_q     <= j_q + 1'b1;
					state_q <= S_RD;
				end
				S_SEPX: begin
					state_q <= S_SEPY;
				end
				S_SEPY: begin
					vx_q    <= upd.val;
					sat_q   <= sat_q | upd.clip;
					state_q <= S_SEPW;
				end
				S_SEPW: begin
					vy_q  <= upd.val;
					sat_q <= sat_q | upd.clip;
					if (na_q != '0) begin
						state_q <= S_AVX_W;
					end else if (nc_q != '0) begin
						state_q <= S_CPX_W;
					end else begin
						state_q <= S_TURN;
					end
				end
				S_AVX_W: begin
					if (div_rsp.done) begin
						state_q <= S_AVX_M;
					end
				end
				S_AVX_M: begin
					vx_q    <= upd.val;
					sat_q   <= sat_q | upd.clip;
					state_q <= S_AVY_W;
				end
				S_AVY_W: begin
					if (div_rsp.done) begin
						state_q <= S_AVY_M;
					end
				end
				S_AVY_M: begin
					vy_q    <= upd.val;
					sat_q   <= sat_q | upd.clip;
					state_q <= (nc_q != '0) ? S_CPX_W : S_TURN;
				end
				S_CPX_W: begin
					if (div_rsp.done) begin
						state_q <= S_CPX_M;
					end
				end
				S_CPX_M: begin
					vx_q    <= upd.val;
					sat_q   <= sat_q | upd.clip;
					state_q <= S_CPY_W;
				end
				S_CPY_W: begin
					if (div_rsp.done) begin
						state_q <= S_CPY_M;
					end
				end
				S_CPY_M: begin
					vy_q    <= upd.val;
					sat_q   <= sat_q | upd.clip;
					state_q <= S_TURN;
				end
				S_TURN: begin
					vx_q    <= tx.val;
					vy_q    <= ty.val;
					sat_q   <= sat_q | tx.clip | ty.clip;
					state_q <= S_SQ1;
				end
				S_SQ1: begin
					sq_q    <= prod_q[31:0];
					state_q <= S_SQ2;
				end
				S_SQ2: begin
					s2_q    <= sq_q + prod_q[31:0];
					state_q <= S_SQ3;
				end
				S_SQ3: begin
					max2_q  <= prod_q[31:0];
					state_q <= S_SQ4;
				end
				S_SQ4: begin
					min2_q  <= prod_q[31:0];
					state_q <= (s2_q == '0) ? S_POSX : S_SQRT_W;
				end
				S_SQRT_W: begin
					if (sqrt_rsp.done) begin
						spd_q     <= sqrt_rsp.root;
						lim_sel_q <= 1'b0;
						state_q   <= S_LIM;
					end
				end
				S_LIM: begin
					if (lim_sel_q ? (s2_q < min2_q) : (s2_q > max2_q)) begin
						state_q <= S_LX_M;
					end else if (!lim_sel_q) begin
						lim_sel_q <= 1'b1;
					end else begin
						state_q <= S_POSX;
					end
				end
				S_LX_M: begin
					state_q <= S_LX_W;
				end
				S_LX_W: begin
					if (div_rsp.done) begin
						vx_q    <= upd.val;
						sat_q   <= sat_q | upd.clip;
						state_q <= S_LY_M;
					end
				end
				S_LY_M: begin
					state_q <= S_LY_W;
				end
				S_LY_W: begin
					if (div_rsp.done) begin
						vy_q  <= upd.val;
						sat_q <= sat_q | upd.clip;
						if (!lim_sel_q) begin
							lim_sel_q <= 1'b1;
							state_q   <= S_LIM;
						end else begin
							state_q <= S_POSX;
						end
					end
				end
				S_POSX: begin
					state_q <= S_POSY;
				end
				S_POSY: begin
					px_q    <= upd.val;
					sat_q   <= sat_q | upd.clip;
					state_q <= S_WB;
				end
				S_WB: begin
					py_q               <= upd.val;
					result_q.out_index <= idx_q;
					result_q.new_pos_x <= px_q;
					result_q.new_pos_y <= upd.val;
					result_q.new_vel_x <= vx_q;
					result_q.new_vel_y <= vy_q;
					result_q.saturated <= sat_q | upd.clip;
					done_q             <= 1'b1;
					state_q            <= S_IDLE;
				end
			endcase
		end
	end

	assign done   = done_q;
	assign result = result_q;

	`BFU_ASSERT_NOW(a_done_after_wb, done, $past(state_q == S_WB), "result strobe without write-back")
	`BFU_ASSERT_NEXT(a_load_stays_free, start && !busy && item.action == ACT_LOAD, !busy, "load word left the block busy")
	`BFU_ASSERT_NOW(a_div_start_free, div_req.start, !div_rsp.busy, "divider restarted while busy")
	`BFU_ASSERT_NOW(a_sqrt_done_wait, sqrt_rsp.done, state_q == S_SQRT_W, "root finished outside its wait")

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import bfu_pkg::*;

	localparam longint CYCLE_LIMIT = 3000000;
	localparam int     SETTLE      = 40;

	localparam logic [2:0] REG_SEP_RADIUS = 3'd0;
	localparam logic [2:0] REG_ALI_RADIUS = 3'd1;
	localparam logic [2:0] REG_COH_RADIUS = 3'd2;
	localparam logic [2:0] REG_SEP_GAIN   = 3'd3;
	localparam logic [2:0] REG_ALI_GAIN   = 3'd4;
	localparam logic [2:0] REG_COH_GAIN   = 3'd5;
	localparam logic [2:0] REG_TURN_STEP  = 3'd6;
	localparam logic [2:0] REG_SPEED      = 3'd7;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	item_t       item = '0;
	logic        done;
	result_t     result;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;

	logic signed [15:0] flock_px [MAX_BIRDS];
	logic signed [15:0] flock_py [MAX_BIRDS];
	logic signed [15:0] flock_vx [MAX_BIRDS];
	logic signed [15:0] flock_vy [MAX_BIRDS];
	bit                 flock_valid [MAX_BIRDS];
	longint             flock_cfg [8];
	int                 cfg_width [8] = '{15, 15, 15, 16, 16, 16, 15, 32};

	result_t pending_updates [$];
	int      errors = 0;
	longint  cycles = 0;
	int      words_sent = 0;
	bit      gaps_on = 1'b1;

	always #2 clk = ~clk;

	boids_flock_update uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic report(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	function automatic longint round_shift(input longint x, input int s);
		return (x + (longint'(1) << (s - 1))) >>> s;
	endfunction

	function automatic longint clip16(input longint x, inout bit clipped);
		if (x > 32767) begin
			clipped = 1'b1;
			return 32767;
		end
		if (x < -32768) begin
			clipped = 1'b1;
			return -32768;
		end
		return x;
	endfunction

	function automatic longint int_sqrt(input longint unsigned n);
		longint unsigned root = 0;
		longint unsigned b = longint'(1) << 62;
		while (b > n)
			b >>= 2;
		while (b != 0) begin
			if (n >= root + b) begin
				n -= root + b;
				root = (root >> 1) + b;
			end else begin
				root >>= 1;
			end
			b >>= 2;
		end
		return longint'(root);
	endfunction

	function automatic result_t flock_step(input int idx);
		result_t r;
		bit      clipped = 1'b0;
		longint  px, py, vx, vy, dx, dy, d2, s2, spd, minv, maxv, tstep;
		longint  sdx = 0, sdy = 0, avx = 0, avy = 0, apx = 0, apy = 0, na = 0, nc = 0;
		px = flock_px[idx];
		py = flock_py[idx];
		vx = flock_vx[idx];
		vy = flock_vy[idx];
		for (int j = 0; j < MAX_BIRDS; j++) begin
			if (j == idx || !flock_valid[j])
				continue;
			dx = px - longint'(flock_px[j]);
			dy = py - longint'(flock_py[j]);
			d2 = dx * dx + dy * dy;
			if (d2 < flock_cfg[REG_SEP_RADIUS] * flock_cfg[REG_SEP_RADIUS]) begin
				sdx += dx;
				sdy += dy;
			end
			if (d2 < flock_cfg[REG_ALI_RADIUS] * flock_cfg[REG_ALI_RADIUS]) begin
				avx += flock_vx[j];
				avy += flock_vy[j];
				na++;
			end
			if (d2 < flock_cfg[REG_COH_RADIUS] * flock_cfg[REG_COH_RADIUS]) begin
				apx += flock_px[j];
				apy += flock_py[j];
				nc++;
			end
		end
		vx = clip16(vx + round_shift(sdx * flock_cfg[REG_SEP_GAIN], 12), clipped);
		vy = clip16(vy + round_shift(sdy * flock_cfg[REG_SEP_GAIN], 12), clipped);
		if (na > 0) begin
			vx = clip16(vx + round_shift((avx / na - vx) * flock_cfg[REG_ALI_GAIN], 16), clipped);
			vy = clip16(vy + round_shift((avy / na - vy) * flock_cfg[REG_ALI_GAIN], 16), clipped);
		end
		if (nc > 0) begin
			vx = clip16(vx + round_shift((apx / nc - px) * flock_cfg[REG_COH_GAIN], 12), clipped);
			vy = clip16(vy + round_shift((apy / nc - py) * flock_cfg[REG_COH_GAIN], 12), clipped);
		end
		tstep = flock_cfg[REG_TURN_STEP];
		if (px < MARGIN_X * 16) vx += tstep;
		if (px > (SCREEN_WIDTH - MARGIN_X) * 16) vx -= tstep;
		if (py < MARGIN_Y * 16) vy += tstep;
		if (py > (SCREEN_HEIGHT - MARGIN_Y) * 16) vy -= tstep;
		vx = clip16(vx, clipped);
		vy = clip16(vy, clipped);
		minv = flock_cfg[REG_SPEED] & 64'hFFFF;
		maxv = (flock_cfg[REG_SPEED] >> 16) & 64'hFFFF;
		s2 = vx * vx + vy * vy;
		if (s2 != 0) begin
			spd = int_sqrt(s2 << 16);
			if (s2 > maxv * maxv) begin
				vx = clip16(vx * maxv * 256 / spd, clipped);
				vy = clip16(vy * maxv * 256 / spd, clipped);
			end
			if (s2 < minv * minv) begin
				vx = clip16(vx * minv * 256 / spd, clipped);
				vy = clip16(vy * minv * 256 / spd, clipped);
			end
		end
		px = clip16(px + round_shift(vx * TIME_STEP, 20), clipped);
		py = clip16(py + round_shift(vy * TIME_STEP, 20), clipped);
		flock_px[idx] = px[15:0];
		flock_py[idx] = py[15:0];
		flock_vx[idx] = vx[15:0];
		flock_vy[idx] = vy[15:0];
		r.out_index = idx[5:0];
		r.new_pos_x = px[15:0];
		r.new_pos_y = py[15:0];
		r.new_vel_x = vx[15:0];
		r.new_vel_y = vy[15:0];
		r.saturated = clipped;
		return r;
	endfunction

	always @(posedge clk) begin
		result_t want;
		if (arst_n && done) begin
			if (pending_updates.size() == 0) begin
				report("unexpected word", result.out_index, -1);
			end else begin
				want = pending_updates.pop_front();
				if (result.out_index !== want.out_index)
					report("out_index", result.out_index, want.out_index);
				if (result.new_pos_x !== want.new_pos_x)
					report("new_pos_x", result.new_pos_x, want.new_pos_x);
				if (result.new_pos_y !== want.new_pos_y)
					report("new_pos_y", result.new_pos_y, want.new_pos_y);
				if (result.new_vel_x !== want.new_vel_x)
					report("new_vel_x", result.new_vel_x, want.new_vel_x);
				if (result.new_vel_y !== want.new_vel_y)
					report("new_vel_y", result.new_vel_y, want.new_vel_y);
				if (result.saturated !== want.saturated)
					report("saturated", result.saturated, want.saturated);
			end
		end
	end

	task automatic send_word(input logic act, input int idx, input int px, input int py,
			input int vx, input int vy);
		item_t w;
		w.action     = act;
		w.bird_index = idx[5:0];
		w.load_pos_x = px[15:0];
		w.load_pos_y = py[15:0];
		w.load_vel_x = vx[15:0];
		w.load_vel_y = vy[15:0];
		if (gaps_on) begin
			while ($urandom_range(99) < 29) begin
				start <= 1'b0;
				@(posedge clk);
			end
		end
		start <= 1'b1;
		item  <= w;
		do
			@(posedge clk);
		while (busy);
		words_sent++;
		if (act == ACT_LOAD) begin
			flock_px[idx]    = w.load_pos_x;
			flock_py[idx]    = w.load_pos_y;
			flock_vx[idx]    = w.load_vel_x;
			flock_vy[idx]    = w.load_vel_y;
			flock_valid[idx] = 1'b1;
		end else if (flock_valid[idx]) begin
			pending_updates.push_back(flock_step(idx));
		end
	endtask

	task automatic load_bird(input int idx, input int px, input int py, input int vx,
			input int vy);
		send_word(ACT_LOAD, idx, px, py, vx, vy);
	endtask

	task automatic update_bird(input int idx);
		send_word(ACT_UPDATE, idx, $urandom, $urandom, $urandom, $urandom);
	endtask

	task automatic drain;
		start <= 1'b0;
		@(posedge clk);
		while (pending_updates.size() != 0 || busy)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_reg(input logic [2:0] idx, input longint value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value[31:0];
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		flock_cfg[idx] = value & ((longint'(1) << cfg_width[idx]) - 1);
		@(posedge clk);
	endtask

	task automatic set_all(input longint sr, input longint ar, input longint cr,
			input longint sg, input longint ag, input longint cg, input longint ts,
			input longint sp);
		set_reg(REG_SEP_RADIUS, sr);
		set_reg(REG_ALI_RADIUS, ar);
		set_reg(REG_COH_RADIUS, cr);
		set_reg(REG_SEP_GAIN, sg);
		set_reg(REG_ALI_GAIN, ag);
		set_reg(REG_COH_GAIN, cg);
		set_reg(REG_TURN_STEP, ts);
		set_reg(REG_SPEED, sp);
	endtask

	task automatic test_reset_defaults;
		update_bird(5);
		load_bird(0, 8000, 5000, 256, 0);
		load_bird(1, 8040, 5010, 0, 256);
		load_bird(2, 8300, 5200, -300, 100);
		update_bird(0);
		update_bird(1);
		update_bird(2);
		update_bird(5);
		drain();
	endtask

	task automatic test_edges_and_extremes;
		load_bird(10, 0, 0, 100, 100);
		load_bird(11, 20479, 11519, -100, -100);
		load_bird(12, -32768, -32768, -32768, -32768);
		load_bird(13, 32767, 32767, 32767, 32767);
		load_bird(14, 10000, 6000, 0, 0);
		for (int i = 10; i <= 14; i++)
			update_bird(i);
		drain();
		set_reg(REG_SPEED, 32'h0100_2000);
		update_bird(10);
		update_bird(14);
		drain();
	endtask

	task automatic test_config_extremes;
		set_all(0, 0, 0, 0, 0, 0, 0, 0);
		update_bird(0);
		update_bird(13);
		drain();
		set_all(32767, 32767, 32767, 65535, 65535, 65535, 32767, 64'hFFFF_FFFF);
		update_bird(1);
		update_bird(12);
		update_bird(2);
		drain();
	endtask

	task automatic random_config;
		if ($urandom_range(9) == 0) begin
			set_all($urandom_range(32767), $urandom_range(32767), $urandom_range(32767),
				$urandom_range(65535), $urandom_range(65535), $urandom_range(65535),
				$urandom_range(32767), $urandom);
		end else begin
			set_all($urandom_range(600), $urandom_range(2500), $urandom_range(2500),
				$urandom_range(8000), $urandom_range(65535), $urandom_range(2000),
				$urandom_range(200),
				(longint'($urandom_range(8192, 256)) << 16) | $urandom_range(1024));
		end
	endtask

	task automatic test_random_flocks;
		int cx, cy, spread, idx, phase;
		phase = 0;
		while (words_sent < 1250) begin
			drain();
			random_config();
			gaps_on = !(phase >= 3 && phase <= 5);
			cx = $urandom_range(20479);
			cy = $urandom_range(11519);
			spread = $urandom_range(1500, 50);
			for (int k = 0; k < 100; k++) begin
				idx = $urandom_range(63);
				if ($urandom_range(99) < 50) begin
					if ($urandom_range(99) < 80)
						load_bird(idx, cx + $urandom_range(2 * spread) - spread,
							cy + $urandom_range(2 * spread) - spread,
							$urandom_range(1200) - 600, $urandom_range(1200) - 600);
					else
						load_bird(idx, $urandom, $urandom, $urandom, $urandom);
				end else begin
					update_bird(idx);
				end
			end
			phase++;
		end
		gaps_on = 1'b1;
	endtask

	initial begin
		for (int i = 0; i < MAX_BIRDS; i++) begin
			flock_px[i] = '0;
			flock_py[i] = '0;
			flock_vx[i] = '0;
			flock_vy[i] = '0;
			flock_valid[i] = 1'b0;
		end
		flock_cfg = '{128, 640, 640, 3277, 3277, 328, 51, 251659008};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_edges_and_extremes();
		test_config_extremes();
		test_random_flocks();
		drain();
		if (pending_updates.size() != 0)
			report("words never returned", 0, pending_updates.size());
		if (errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// File: filelist.f
+incdir+rtl
rtl/bfu_pkg.sv
rtl/bfu_table.sv
rtl/bfu_div.sv
rtl/bfu_sqrt.sv
rtl/boids_flock_update.sv
sim/testbench.sv
